// ===== sv/mlfq_ready_queue_scheduler_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MLFQ_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define MLFQ_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MLFQRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define MLFQRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlfqrq_pkg.sv =====
// ============================================================================
// mlfqrq_pkg
// Types and constants of the multilevel ready-queue scheduler.
// ============================================================================
`default_nettype none
package mlfqrq_pkg;

    localparam int DEF_NUM_SLOTS = 64;
    localparam logic [9:0] AGING_PERIOD_RESET = 10'd50;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [1:0] LEVEL_0 = 2'd0;
    localparam logic [1:0] LEVEL_1 = 2'd1;
    localparam logic [1:0] LEVEL_2 = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AGE_L1,
        ST_AGE_L2
    } state_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } chain_ctl_t;

    typedef struct packed {
        logic [1:0]  prio;
        logic [15:0] pid;
    } prio_key_t;

endpackage
`default_nettype wire

// ===== sv/mlfqrq_fifo_cell.sv =====
// ============================================================================
// mlfqrq_fifo_cell
// One cell of a shift-out FIFO: loads a pushed slot or takes its upper neighbor on pop.
// ============================================================================
`default_nettype none
module mlfqrq_fifo_cell
    import mlfqrq_pkg::*;
#(
    parameter int SW = 6
) (
    input  wire logic          aclk,
    input  wire chain_ctl_t    ctl,
    input  wire logic [SW-1:0] new_slot,
    input  wire logic [SW-1:0] next_slot,
    output logic [SW-1:0]      slot_q
);

    logic [SW-1:0] slot_reg;
    logic [SW-1:0] slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (ctl.pop) begin
            slot_next = next_slot;
        end else if (ctl.ins) begin
            slot_next = new_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_q = slot_reg;

endmodule
`default_nettype wire

// ===== sv/mlfqrq_prio_cell.sv =====
// ============================================================================
// mlfqrq_prio_cell
// One cell of the sorted level 2 chain; cell 0 holds the entry served next.
// ============================================================================
`default_nettype none
module mlfqrq_prio_cell
    import mlfqrq_pkg::*;
#(
    parameter int SW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire chain_ctl_t    ctl,
    input  wire prio_key_t     new_key,
    input  wire logic [SW-1:0] new_slot,
    input  wire prio_key_t     prev_key,
    input  wire logic [SW-1:0] prev_slot,
    input  wire logic          prev_valid,
    input  wire logic          prev_better,
    input  wire prio_key_t     next_key,
    input  wire logic [SW-1:0] next_slot,
    input  wire logic          next_valid,
    output prio_key_t          key_q,
    output logic [SW-1:0]      slot_q,
    output logic               valid_q,
    output logic               better
);

    prio_key_t     key_reg, key_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          valid_reg, valid_next;

    // An equal key is not better, so the newer entry lands in front of it.
    assign better = valid_reg && ((key_reg.prio > new_key.prio) ||
                    ((key_reg.prio == new_key.prio) && (key_reg.pid < new_key.pid)));

    always_comb begin
        key_next   = key_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (ctl.pop) begin
            key_next   = next_key;
            slot_next  = next_slot;
            valid_next = next_valid;
        end else if (ctl.ins && !better) begin
            if (prev_better) begin
                key_next   = new_key;
                slot_next  = new_slot;
                valid_next = 1'b1;
            end else begin
                key_next   = prev_key;
                slot_next  = prev_slot;
                valid_next = prev_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

    assign key_q   = key_reg;
    assign slot_q  = slot_reg;
    assign valid_q = valid_reg;

endmodule
`default_nettype wire

// ===== sv/mlfq_ready_queue_scheduler_unit.sv =====
// Latency: a result is registered at its input transfer and shows in the next cycle.
// Throughput: one item per cycle while idle, unless a held result stalls on m_tready. A tick
// that runs an aging pass then keeps s_tready low while level 1 and then level 2 entries
// move to level 0 through ST_AGE_L1 and ST_AGE_L2; each move is one shift of the chains.
// Reset: synchronous active-low aresetn empties all queues, clears the queued
// flags and tick count, and restores the mode and aging period registers.
// ============================================================================
// mlfq_ready_queue_scheduler_unit
// Ready-queue scheduler with a FCFS mode and a three level feedback mode.
// ============================================================================
`default_nettype none
module mlfq_ready_queue_scheduler_unit
    import mlfqrq_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] proc_slot, [7:6] level, [9:8] task_priority, [25:10] task_pid
    input  wire logic [31:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] selected_slot, [6] selected_valid, [7] accepted, [8] aged
    output logic [15:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    state_t state_reg, state_next;

    logic          mode_reg;
    logic [9:0]    period_reg;
    logic [9:0]    tick_reg, tick_next;
    logic [CW-1:0] l0_cnt_reg, l0_cnt_next, l1_cnt_reg, l1_cnt_next;
    logic [NUM_SLOTS-1:0] flag_reg, flag_next;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg, m_tdata_next;

    logic [1:0]    op;
    logic [5:0]    in_slot;
    logic [1:0]    in_level;
    prio_key_t     in_key;
    logic [SW-1:0] slot_idx;
    logic          in_range;
    logic          xfer;
    logic [9:0]    tick_inc, period_eff;
    logic          wrap;

    logic          l0_push, l0_pop, l1_push, l1_pop;
    chain_ctl_t    l2_ctl;
    logic [SW-1:0] l0_new;
    logic          enq_ok, deq_ok, aged;
    logic [SW-1:0] sel_idx;

    logic [SW-1:0] l0_slot [NUM_SLOTS];
    logic [SW-1:0] l1_slot [NUM_SLOTS];
    prio_key_t     l2_key  [NUM_SLOTS];
    logic [SW-1:0] l2_slot [NUM_SLOTS];
    logic          l2_valid[NUM_SLOTS];
    logic          l2_better[NUM_SLOTS];

    assign op       = s_tuser;
    assign in_slot  = s_tdata[5:0];
    assign in_level = s_tdata[7:6];
    assign in_key   = '{prio: s_tdata[9:8], pid: s_tdata[25:10]};
    assign slot_idx = SW'(in_slot);
    assign in_range = 32'(in_slot) < NUM_SLOTS;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign xfer     = s_tvalid && s_tready;

    assign tick_inc   = tick_reg + 10'd1;
    assign period_eff = (period_reg == 10'd0) ? 10'd1 : period_reg;
    assign wrap       = tick_inc >= period_eff;

    // Cell chains.
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cells
        chain_ctl_t l0_ctl, l1_ctl;
        logic [SW-1:0] l0_nx, l1_nx, l2_nx_slot, l2_pv_slot;
        prio_key_t l2_nx_key, l2_pv_key;
        logic l2_nx_valid, l2_pv_valid, l2_pv_better;

        assign l0_ctl = '{ins: l0_push && (l0_cnt_reg == CW'(k)), pop: l0_pop};
        assign l1_ctl = '{ins: l1_push && (l1_cnt_reg == CW'(k)), pop: l1_pop};

        if (k < NUM_SLOTS - 1) begin : g_mid
            assign l0_nx       = l0_slot[k+1];
            assign l1_nx       = l1_slot[k+1];
            assign l2_nx_slot  = l2_slot[k+1];
            assign l2_nx_key   = l2_key[k+1];
            assign l2_nx_valid = l2_valid[k+1];
        end else begin : g_last
            assign l0_nx       = '0;
            assign l1_nx       = '0;
            assign l2_nx_slot  = '0;
            assign l2_nx_key   = '0;
            assign l2_nx_valid = 1'b0;
        end

        if (k > 0) begin : g_prev
            assign l2_pv_slot   = l2_slot[k-1];
            assign l2_pv_key    = l2_key[k-1];
            assign l2_pv_valid  = l2_valid[k-1];
            assign l2_pv_better = l2_better[k-1];
        end else begin : g_first
            assign l2_pv_slot   = '0;
            assign l2_pv_key    = '0;
            assign l2_pv_valid  = 1'b0;
            assign l2_pv_better = 1'b1;
        end

        mlfqrq_fifo_cell #(.SW(SW)) u_l0 (
            .aclk(aclk), .ctl(l0_ctl), .new_slot(l0_new),
            .next_slot(l0_nx), .slot_q(l0_slot[k])
        );

        mlfqrq_fifo_cell #(.SW(SW)) u_l1 (
            .aclk(aclk), .ctl(l1_ctl), .new_slot(slot_idx),
            .next_slot(l1_nx), .slot_q(l1_slot[k])
        );

        mlfqrq_prio_cell #(.SW(SW)) u_l2 (
            .aclk(aclk), .aresetn(aresetn), .ctl(l2_ctl),
            .new_key(in_key), .new_slot(slot_idx),
            .prev_key(l2_pv_key), .prev_slot(l2_pv_slot),
            .prev_valid(l2_pv_valid), .prev_better(l2_pv_better),
            .next_key(l2_nx_key), .next_slot(l2_nx_slot), .next_valid(l2_nx_valid),
            .key_q(l2_key[k]), .slot_q(l2_slot[k]),
            .valid_q(l2_valid[k]), .better(l2_better[k])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (xfer && (op == OP_TICK) && wrap && mode_reg) begin
                    state_next = ST_AGE_L1;
                end
            end
            ST_AGE_L1: begin
                if (l1_cnt_reg == '0) begin
                    state_next = ST_AGE_L2;
                end
            end
            ST_AGE_L2: begin
                if (!l2_valid[0]) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Queue controls.
    always_comb begin
        l0_push = 1'b0;
        l0_pop  = 1'b0;
        l1_push = 1'b0;
        l1_pop  = 1'b0;
        l2_ctl  = '{ins: 1'b0, pop: 1'b0};
        l0_new  = slot_idx;
        enq_ok  = 1'b0;
        deq_ok  = 1'b0;
        aged    = 1'b0;
        sel_idx = '0;
        case (state_reg)
            ST_IDLE: begin
                if (xfer) begin
                    case (op)
                        OP_ENQUEUE: begin
                            if (in_range && !flag_reg[slot_idx]) begin
                                if (!mode_reg || in_level == LEVEL_0) begin
                                    l0_push = 1'b1;
                                    enq_ok  = 1'b1;
                                end else if (in_level == LEVEL_1) begin
                                    l1_push = 1'b1;
                                    enq_ok  = 1'b1;
                                end else if (in_level == LEVEL_2) begin
                                    l2_ctl.ins = 1'b1;
                                    enq_ok     = 1'b1;
                                end
                            end
                        end
                        OP_DEQUEUE: begin
                            if (l0_cnt_reg != '0) begin
                                l0_pop  = 1'b1;
                                deq_ok  = 1'b1;
                                sel_idx = l0_slot[0];
                            end else if (mode_reg && l1_cnt_reg != '0) begin
                                l1_pop  = 1'b1;
                                deq_ok  = 1'b1;
                                sel_idx = l1_slot[0];
                            end else if (mode_reg && l2_valid[0]) begin
                                l2_ctl.pop = 1'b1;
                                deq_ok     = 1'b1;
                                sel_idx    = l2_slot[0];
                            end
                        end
                        OP_TICK: aged = wrap && mode_reg;
                        default: ;
                    endcase
                end
            end
            ST_AGE_L1: begin
                if (l1_cnt_reg != '0) begin
                    l1_pop  = 1'b1;
                    l0_push = 1'b1;
                    l0_new  = l1_slot[0];
                end
            end
            ST_AGE_L2: begin
                if (l2_valid[0]) begin
                    l2_ctl.pop = 1'b1;
                    l0_push    = 1'b1;
                    l0_new     = l2_slot[0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        l0_cnt_next = l0_cnt_reg + CW'(l0_push) - CW'(l0_pop);
        l1_cnt_next = l1_cnt_reg + CW'(l1_push) - CW'(l1_pop);
        flag_next   = flag_reg;
        if (enq_ok) begin
            flag_next[slot_idx] = 1'b1;
        end
        if (deq_ok) begin
            flag_next[sel_idx] = 1'b0;
        end
        tick_next = tick_reg;
        if (xfer && op == OP_TICK) begin
            tick_next = wrap ? 10'd0 : tick_inc;
        end
        m_tdata_next = {7'd0, aged, enq_ok, deq_ok, 6'(sel_idx)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            period_reg   <= AGING_PERIOD_RESET;
            tick_reg     <= '0;
            l0_cnt_reg   <= '0;
            l1_cnt_reg   <= '0;
            flag_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            l0_cnt_reg <= l0_cnt_next;
            l1_cnt_reg <= l1_cnt_next;
            flag_reg   <= flag_next;
            if (xfer) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_MODE) begin
                    mode_reg <= pwdata[0];
                end else begin
                    period_reg <= pwdata[9:0];
                end
            end
        end
        if (xfer) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_PERIOD) ? {22'd0, period_reg} : {31'd0, mode_reg};

endmodule
`default_nettype wire

// ===== sv/mlfqrq_checker.sv =====
// ============================================================================
// mlfqrq_checker
// Port-level checks of the scheduler's result channel and its link to input transfers.
// ============================================================================
`default_nettype none
`include "mlfq_ready_queue_scheduler_unit_defines.svh"
module mlfqrq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    `MLFQRQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `MLFQRQ_ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid, "input transfer gave no result")
    `MLFQRQ_ASSERT_IMP(a_excl, m_tvalid && m_tdata[6], !m_tdata[7] && !m_tdata[8], "mixed flags")
    `MLFQRQ_ASSERT_IMP(a_zero, m_tvalid && !m_tdata[6], m_tdata[5:0] == 6'd0, "slot without select")

endmodule

bind mlfq_ready_queue_scheduler_unit mlfqrq_checker u_mlfqrq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== test/mlfq_ready_queue_scheduler_unit_test.sv =====
// ============================================================================
// mlfq_ready_queue_scheduler_unit_test
// Self-checking test of the ready-queue scheduler. Directed enqueue, dequeue
// and tick sequences in both modes are followed by random traffic over several
// mode and aging-period settings. A local queue model predicts every result.
// Both stream sides see random idle and stall patterns.
// ============================================================================
`default_nettype none
module mlfq_ready_queue_scheduler_unit_test;
    import mlfqrq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam logic [2:0] ADDR_MODE   = {1'b0, REG_MODE, 1'b0} << 1;
    localparam logic [2:0] ADDR_PERIOD = {1'b0, REG_PERIOD, 1'b0} << 1;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         DRAIN_WAIT  = 80;

    typedef struct packed {
        logic [5:0] sel;
        logic       found;
        logic       stored;
        logic       aged;
    } sched_result_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic [1:0]  prio;
        logic [15:0] pid;
    } l2_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [5:0] slot, [7:6] level, [9:8] priority, [25:10] pid
    logic [1:0]  s_tuser = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [5:0] slot, [6] found, [7] accepted, [8] aged
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Scheduler state mirrored by the predictor.
    logic [5:0]    lvl0_q[$];
    logic [5:0]    lvl1_q[$];
    l2_entry_t     lvl2_q[$];    // pop order: last element pops first
    logic          slot_busy[64];
    logic [9:0]    tick_cnt;
    logic          mode_mlfq;
    logic [9:0]    period_reg;

    sched_result_t expected_results[$];
    int            error_count = 0;
    int            burst_left = 0;
    int            idle_cycles = 0;

    mlfq_ready_queue_scheduler_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    function automatic sched_result_t schedule_step(logic [1:0] op, logic [5:0] slot,
                                                    logic [1:0] lvl, logic [1:0] prio,
                                                    logic [15:0] pid);
        sched_result_t r;
        int            i;
        l2_entry_t     e;
        logic [9:0]    per;
        r = '0;
        case (op)
            OP_ENQUEUE: begin
                if (!slot_busy[slot]) begin
                    if (!mode_mlfq || lvl == LEVEL_0) begin
                        if (lvl0_q.size() < 64) lvl0_q.push_back(slot);
                        r.stored = 1'b1;
                    end else if (lvl == LEVEL_1) begin
                        if (lvl1_q.size() < 64) lvl1_q.push_back(slot);
                        r.stored = 1'b1;
                    end else if (lvl == LEVEL_2) begin
                        if (lvl2_q.size() < 64) begin
                            i = lvl2_q.size();
                            while (i > 0 && (lvl2_q[i-1].prio > prio ||
                                   (lvl2_q[i-1].prio == prio && lvl2_q[i-1].pid < pid)))
                                i--;
                            e = '{slot: slot, prio: prio, pid: pid};
                            lvl2_q.insert(i, e);
                        end
                        r.stored = 1'b1;
                    end
                    if (r.stored) slot_busy[slot] = 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (lvl0_q.size() > 0) begin
                    r.sel = lvl0_q.pop_front();
                    r.found = 1'b1;
                end else if (mode_mlfq && lvl1_q.size() > 0) begin
                    r.sel = lvl1_q.pop_front();
                    r.found = 1'b1;
                end else if (mode_mlfq && lvl2_q.size() > 0) begin
                    e = lvl2_q.pop_back();
                    r.sel = e.slot;
                    r.found = 1'b1;
                end
                if (r.found) slot_busy[r.sel] = 1'b0;
            end
            OP_TICK: begin
                per = (period_reg == 0) ? 10'd1 : period_reg;
                tick_cnt = tick_cnt + 10'd1;
                if (tick_cnt >= per) begin
                    tick_cnt = '0;
                    if (mode_mlfq) begin
                        while (lvl1_q.size() > 0) lvl0_q.push_back(lvl1_q.pop_front());
                        while (lvl2_q.size() > 0) begin
                            e = lvl2_q.pop_back();
                            lvl0_q.push_back(e.slot);
                        end
                        r.aged = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one item, honoring the burst and gap pattern of the sender.
    task automatic send_item(logic [1:0] op, logic [5:0] slot, logic [1:0] lvl,
                             logic [1:0] prio, logic [15:0] pid);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, pid, prio, lvl, slot};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(schedule_step(op, slot, lvl, prio, pid));
    endtask

    // Drops valid and lets the block settle, including a possible aging drain.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (expected_results.size() != 0 || !s_tready);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MODE) mode_mlfq = value[0];
        else period_reg = value[9:0];
    endtask

    task automatic test_fcfs_directed();
        send_item(OP_ENQUEUE, 6'd0, LEVEL_2, 2'd3, 16'hFFFF);
        send_item(OP_ENQUEUE, 6'd63, LEVEL_1, 2'd0, 16'h0000);
        send_item(OP_ENQUEUE, 6'd0, LEVEL_0, 2'd1, 16'h1234);
        send_item(OP_DEQUEUE, 6'd0, 2'd0, 2'd0, 16'd0);
        send_item(OP_DEQUEUE, 6'd0, 2'd0, 2'd0, 16'd0);
        send_item(OP_DEQUEUE, 6'd63, 2'd3, 2'd3, 16'hFFFF);
        send_item(OP_NOP, 6'd63, 2'd3, 2'd3, 16'hFFFF);
        send_item(OP_TICK, 6'd0, 2'd0, 2'd0, 16'd0);
        wait_drained();
    endtask

    task automatic test_mlfq_directed();
        write_reg(ADDR_MODE, 32'd1);
        write_reg(ADDR_PERIOD, 32'd2);
        send_item(OP_ENQUEUE, 6'd5, 2'd3, 2'd0, 16'd0);
        send_item(OP_ENQUEUE, 6'd10, LEVEL_2, 2'd3, 16'hFFFF);
        // Same priority and pid: the newer entry must pop first.
        send_item(OP_ENQUEUE, 6'd11, LEVEL_2, 2'd3, 16'hFFFF);
        send_item(OP_ENQUEUE, 6'd12, LEVEL_2, 2'd0, 16'd0);
        send_item(OP_ENQUEUE, 6'd13, LEVEL_1, 2'd2, 16'd7);
        send_item(OP_ENQUEUE, 6'd14, LEVEL_0, 2'd1, 16'd9);
        send_item(OP_DEQUEUE, 6'd0, 2'd0, 2'd0, 16'd0);
        send_item(OP_TICK, 6'd0, 2'd0, 2'd0, 16'd0);
        send_item(OP_TICK, 6'd0, 2'd0, 2'd0, 16'd0);
        repeat (5) send_item(OP_DEQUEUE, 6'd0, 2'd0, 2'd0, 16'd0);
        wait_drained();
    endtask

    task automatic test_random(logic mode, logic [9:0] period, int count);
        logic [1:0] op;
        int         pick;
        write_reg(ADDR_MODE, {31'd0, mode});
        write_reg(ADDR_PERIOD, {22'd0, period});
        repeat (count) begin
            pick = $urandom_range(0, 99);
            op = (pick < 48) ? OP_ENQUEUE : (pick < 83) ? OP_DEQUEUE :
                 (pick < 98) ? OP_TICK : OP_NOP;
            send_item(op, 6'($urandom_range(0, 63)),
                      ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                      2'($urandom_range(0, 3)),
                      ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom));
        end
        wait_drained();
    endtask

    // Receiver stall pattern: stretches of always-ready, light and heavy stalls.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[5:0] !== want.sel) begin
                    $error("selected_slot: expected %0d, got %0d", want.sel, m_tdata[5:0]);
                    error_count++;
                end
                if (m_tdata[6] !== want.found) begin
                    $error("selected_valid: expected %0d, got %0d", want.found, m_tdata[6]);
                    error_count++;
                end
                if (m_tdata[7] !== want.stored) begin
                    $error("accepted: expected %0d, got %0d", want.stored, m_tdata[7]);
                    error_count++;
                end
                if (m_tdata[8] !== want.aged) begin
                    $error("aged: expected %0d, got %0d", want.aged, m_tdata[8]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        tick_cnt   = '0;
        mode_mlfq  = 1'b0;
        period_reg = AGING_PERIOD_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fcfs_directed();
        test_mlfq_directed();
        test_random(1'b1, 10'd5, 300);
        test_random(1'b1, 10'd1023, 200);
        // Lowering the period below the running count ages on the next tick.
        test_random(1'b1, 10'd1, 150);
        test_random(1'b1, 10'd0, 150);
        // Back to first-come first-served with entries left in levels 1 and 2.
        test_random(1'b0, 10'd3, 250);
        test_random(1'b1, 10'd17, 300);
        test_random(1'b0, 10'd50, 150);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
